// File: src/bdc_pkg.sv
// Shared types and constants of the B-dot detumbling controller.
package bdc_pkg;

  // Default width of one field component in sensor counts.
  localparam int FIELD_WIDTH_DEF = 16;

  // Register and field widths.
  localparam int GAIN_W     = 8;
  localparam int WEIGHT_W   = 17;
  localparam int SCALE_W    = 32;
  localparam int GS_W       = GAIN_W + SCALE_W;
  localparam int NORM_W     = 16;
  localparam int CUR_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Unity weight in Q1.16.
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  // Register reset values.
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 8'd0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'h10000;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 32'h0001_0000;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd2;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [WEIGHT_W-1:0] weight;
    logic [SCALE_W-1:0]  scale;
  } cfg_t;

endpackage

// File: src/bdc_stream_ifs.sv
// Valid/ready channel interfaces for field samples and coil current commands.
interface bdc_in_if
  import bdc_pkg::*;
#(
  parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [FIELD_WIDTH-1:0] field_x;
  logic signed [FIELD_WIDTH-1:0] field_y;
  logic signed [FIELD_WIDTH-1:0] field_z;
  logic signed [FIELD_WIDTH-1:0] prev_field_x;
  logic signed [FIELD_WIDTH-1:0] prev_field_y;
  logic signed [FIELD_WIDTH-1:0] prev_field_z;
  logic        [NORM_W-1:0]      field_norm;

  modport source (
    output valid, field_x, field_y, field_z,
    output prev_field_x, prev_field_y, prev_field_z, field_norm,
    input  ready
  );
  modport sink (
    input  valid, field_x, field_y, field_z,
    input  prev_field_x, prev_field_y, prev_field_z, field_norm,
    output ready
  );
endinterface

interface bdc_out_if
  import bdc_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [CUR_W-1:0] coil_current_x;
  logic signed [CUR_W-1:0] coil_current_y;
  logic signed [CUR_W-1:0] coil_current_z;
  logic                    saturated;

  modport source (
    output valid, coil_current_x, coil_current_y, coil_current_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, coil_current_x, coil_current_y, coil_current_z, saturated,
    output ready
  );
endinterface

// File: src/bdc_mul.sv
// Shared signed multiplier with a registered product.
module bdc_mul
  import bdc_pkg::*;
#(
  parameter int A_W = 18,
  parameter int B_W = GS_W + 1
) (
  input  logic                     clk,
  input  logic signed [A_W-1:0]     a,
  input  logic signed [B_W-1:0]     b,
  output logic signed [A_W+B_W-1:0] p_r
);

  // One product per cycle, available in the following cycle.
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// File: src/bdc_seq.sv
// Sequencer and datapath: blend, scale and rounding division, one axis at a time.
module bdc_seq
  import bdc_pkg::*;
#(
  parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [FIELD_WIDTH-1:0] field_x,
  input  logic signed [FIELD_WIDTH-1:0] field_y,
  input  logic signed [FIELD_WIDTH-1:0] field_z,
  input  logic signed [FIELD_WIDTH-1:0] prev_field_x,
  input  logic signed [FIELD_WIDTH-1:0] prev_field_y,
  input  logic signed [FIELD_WIDTH-1:0] prev_field_z,
  input  logic        [NORM_W-1:0]      field_norm,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [CUR_W-1:0]       coil_current_x,
  output logic signed [CUR_W-1:0]       coil_current_y,
  output logic signed [CUR_W-1:0]       coil_current_z,
  output logic                          saturated
);

  // Datapath widths.
  localparam int DW    = FIELD_WIDTH + 1;            // field difference
  localparam int BW    = FIELD_WIDTH + 17;           // blended difference, Q.16
  localparam int MAGW  = BW - 1;                     // blend magnitude
  localparam int CH_W  = 16;                         // multiplier chunk of the magnitude
  localparam int NCH   = (MAGW + CH_W - 1) / CH_W;
  localparam int CIW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int A_W   = WEIGHT_W + 1;
  localparam int OPB_W = (DW > GS_W + 1) ? DW : GS_W + 1;
  localparam int PW    = A_W + OPB_W;
  localparam int ACCW  = NCH * CH_W + GS_W;
  localparam int RW    = ACCW + 1;
  localparam int QUOT_W     = CUR_W;
  localparam int HALF_SHIFT = 31;
  localparam int DEN_SHIFT  = 32;

  localparam logic [CIW-1:0]   CH_TOP  = CIW'(NCH - 1);
  localparam logic [3:0]       DIV_TOP = 4'(QUOT_W);
  localparam logic [1:0]       AX_LAST = 2'd2;
  localparam logic [QUOT_W-1:0] Q_POS_MAX = 8'd127;
  localparam logic [QUOT_W-1:0] Q_NEG_MAX = 8'd128;
  localparam logic signed [CUR_W-1:0] CUR_POS_SAT = 8'sd127;
  localparam logic signed [CUR_W-1:0] CUR_NEG_SAT = -8'sd128;

  typedef enum logic [3:0] {
    S_IDLE, S_GS, S_GSCAP, S_BL1, S_BL2, S_BL3,
    S_MISS, S_MACC, S_RND, S_DIV, S_AXEND, S_OUT
  } state_t;

  // Control registers.
  state_t              state_r, state_nxt;
  logic [1:0]          ax_r, ax_nxt;
  logic [CIW-1:0]      chunk_r, chunk_nxt;
  logic [3:0]          div_cnt_r, div_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] ld_r [3];
  logic signed [DW-1:0] ld_nxt [3];

  // Datapath registers.
  logic signed [DW-1:0]   d_r [3];
  logic signed [DW-1:0]   d_nxt [3];
  logic [NORM_W-1:0]      norm_r, norm_nxt;
  logic [WEIGHT_W-1:0]    w_r, w_nxt;
  logic [WEIGHT_W-1:0]    wc_r, wc_nxt;
  logic [GS_W-1:0]        gs_r, gs_nxt;
  logic signed [PW-1:0]   t1_r, t1_nxt;
  logic [NCH*CH_W-1:0]    mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [ACCW-1:0]        acc_r, acc_nxt;
  logic [RW-1:0]          rem_r, rem_nxt;
  logic [RW-1:0]          den_r, den_nxt;
  logic [QUOT_W-1:0]      q_r, q_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   sat_r, sat_nxt;
  logic signed [CUR_W-1:0] cur_r [3];
  logic signed [CUR_W-1:0] cur_nxt [3];
  logic signed [CUR_W-1:0] ox_r, ox_nxt;
  logic signed [CUR_W-1:0] oy_r, oy_nxt;
  logic signed [CUR_W-1:0] oz_r, oz_nxt;
  logic                   osat_r, osat_nxt;

  // Shared multiplier.
  logic signed [A_W-1:0]   mul_a;
  logic signed [OPB_W-1:0] mul_b;
  logic signed [PW-1:0]    mul_p;

  bdc_mul #(
    .A_W (A_W),
    .B_W (OPB_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // Helper values.
  logic signed [PW-1:0]  blend_sum;
  logic signed [BW-1:0]  blend;
  logic signed [BW-1:0]  blend_abs;
  logic [CH_W-1:0]       chunk;
  logic                  ge;
  logic signed [CUR_W-1:0] axis_cur;
  logic                  axis_sat;
  logic [WEIGHT_W-1:0]   w_clamp;

  assign blend_sum = t1_r + mul_p;
  assign blend     = blend_sum[BW-1:0];
  assign blend_abs = blend[BW-1] ? -blend : blend;
  assign chunk     = mag_r[chunk_r*CH_W +: CH_W];
  assign ge        = (rem_r >= den_r);
  assign w_clamp   = (cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.weight;

  // Axis result from the rounded quotient, saturated to the int8 range.
  always_comb begin
    axis_cur = '0;
    axis_sat = 1'b0;
    if (neg_r) begin
      if (ovf_r || (q_r > Q_NEG_MAX)) begin
        axis_cur = CUR_NEG_SAT;
        axis_sat = 1'b1;
      end else begin
        axis_cur = -q_r;
      end
    end else begin
      if (ovf_r || (q_r > Q_POS_MAX)) begin
        axis_cur = CUR_POS_SAT;
        axis_sat = 1'b1;
      end else begin
        axis_cur = q_r;
      end
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_GS: begin
        mul_a = A_W'(cfg.gain);
        mul_b = OPB_W'(cfg.scale);
      end
      S_BL1: begin
        mul_a = A_W'(w_r);
        mul_b = OPB_W'(d_r[ax_r]);
      end
      S_BL2: begin
        mul_a = A_W'(wc_r);
        mul_b = OPB_W'(ld_r[ax_r]);
      end
      S_MISS: begin
        mul_a = A_W'(chunk);
        mul_b = OPB_W'(gs_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Next-state and datapath logic.
  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    chunk_nxt     = chunk_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ld_nxt        = ld_r;
    d_nxt         = d_r;
    norm_nxt      = norm_r;
    w_nxt         = w_r;
    wc_nxt        = wc_r;
    gs_nxt        = gs_r;
    t1_nxt        = t1_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    q_nxt         = q_r;
    ovf_nxt       = ovf_r;
    sat_nxt       = sat_r;
    cur_nxt       = cur_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    oz_nxt        = oz_r;
    osat_nxt      = osat_r;
    in_ready      = 1'b0;

    case (state_r)
      // Take a sample: form the differences and latch norm and weights.
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          d_nxt[0] = DW'(field_x) - DW'(prev_field_x);
          d_nxt[1] = DW'(field_y) - DW'(prev_field_y);
          d_nxt[2] = DW'(field_z) - DW'(prev_field_z);
          norm_nxt = (field_norm == '0) ? NORM_W'(1) : field_norm;
          w_nxt    = w_clamp;
          wc_nxt   = WEIGHT_ONE - w_clamp;
          ax_nxt   = '0;
          sat_nxt  = 1'b0;
          state_nxt = S_GS;
        end
      end
      S_GS: begin
        state_nxt = S_GSCAP;
      end
      S_GSCAP: begin
        gs_nxt    = mul_p[GS_W-1:0];
        state_nxt = S_BL1;
      end
      S_BL1: begin
        state_nxt = S_BL2;
      end
      S_BL2: begin
        t1_nxt    = mul_p;
        state_nxt = S_BL3;
      end
      // Blend done: keep its magnitude and the sign of the command.
      S_BL3: begin
        mag_nxt   = (NCH*CH_W)'(blend_abs[MAGW-1:0]);
        neg_nxt   = !blend[BW-1] && (blend != '0);
        acc_nxt   = '0;
        chunk_nxt = CH_TOP;
        state_nxt = S_MISS;
      end
      S_MISS: begin
        state_nxt = S_MACC;
      end
      // Accumulate partial products, most significant chunk first.
      S_MACC: begin
        acc_nxt = (acc_r << CH_W) + {{(ACCW-PW){1'b0}}, mul_p};
        if (chunk_r == '0) begin
          state_nxt = S_RND;
        end else begin
          chunk_nxt = chunk_r - 1'b1;
          state_nxt = S_MISS;
        end
      end
      // Add half the divisor for round to nearest, ties away from zero.
      S_RND: begin
        rem_nxt     = RW'(acc_r) + RW'({norm_r, {HALF_SHIFT{1'b0}}});
        den_nxt     = RW'({norm_r, {(DEN_SHIFT + QUOT_W){1'b0}}});
        div_cnt_nxt = DIV_TOP;
        q_nxt       = '0;
        ovf_nxt     = 1'b0;
        state_nxt   = S_DIV;
      end
      // Restoring division, one quotient bit per cycle after an overflow check.
      S_DIV: begin
        if (div_cnt_r == DIV_TOP) begin
          if (ge) begin
            ovf_nxt   = 1'b1;
            state_nxt = S_AXEND;
          end else begin
            den_nxt     = den_r >> 1;
            div_cnt_nxt = div_cnt_r - 1'b1;
          end
        end else begin
          q_nxt   = {q_r[QUOT_W-2:0], ge};
          den_nxt = den_r >> 1;
          if (ge) begin
            rem_nxt = rem_r - den_r;
          end
          if (div_cnt_r == '0) begin
            state_nxt = S_AXEND;
          end else begin
            div_cnt_nxt = div_cnt_r - 1'b1;
          end
        end
      end
      // Store the axis result and the difference for the next sample.
      S_AXEND: begin
        cur_nxt[ax_r] = axis_cur;
        sat_nxt       = sat_r | axis_sat;
        ld_nxt[ax_r]  = d_r[ax_r];
        if (ax_r == AX_LAST) begin
          state_nxt = S_OUT;
        end else begin
          ax_nxt    = ax_r + 1'b1;
          state_nxt = S_BL1;
        end
      end
      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          ox_nxt        = cur_r[0];
          oy_nxt        = cur_r[1];
          oz_nxt        = cur_r[2];
          osat_nxt      = sat_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      chunk_r     <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      ld_r[0]     <= '0;
      ld_r[1]     <= '0;
      ld_r[2]     <= '0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      chunk_r     <= chunk_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ld_r        <= ld_nxt;
    end
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    oz_r   <= oz_nxt;
    osat_r <= osat_nxt;
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    norm_r <= norm_nxt;
    w_r    <= w_nxt;
    wc_r   <= wc_nxt;
    gs_r   <= gs_nxt;
    t1_r   <= t1_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    ovf_r  <= ovf_nxt;
    sat_r  <= sat_nxt;
    cur_r  <= cur_nxt;
  end

  assign out_valid      = out_valid_r;
  assign coil_current_x = ox_r;
  assign coil_current_y = oy_r;
  assign coil_current_z = oz_r;
  assign saturated      = osat_r;

endmodule

// File: src/bdot_detumble_controller_core.sv
// Top level of the B-dot detumbling controller: configuration registers and channels.
// A result follows each accepted sample once all three axes are done; an axis whose quotient
// overflows leaves the division at the overflow check. The block takes no new sample until
// its result is in the output register, since the single shared multiplier and the bit-serial
// rounding divider serve the three axes in turn.
// Reset: gain 0, weight 65536, scale 65536, stored differences zero, no result pending.
module bdot_detumble_controller_core
  import bdc_pkg::*;
#(
  parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  bdc_in_if.sink                in_ch,
  bdc_out_if.source             out_ch
);

  cfg_t cfg_r, cfg_nxt;

  // Register writes by index; indexes past the list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN:   cfg_nxt.gain   = cfg_wdata[GAIN_W-1:0];
        CFG_WEIGHT: cfg_nxt.weight = cfg_wdata[WEIGHT_W-1:0];
        CFG_SCALE:  cfg_nxt.scale  = cfg_wdata[SCALE_W-1:0];
        default:    cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain   <= GAIN_RST;
      cfg_r.weight <= WEIGHT_RST;
      cfg_r.scale  <= SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer with the shared multiplier.
  bdc_seq #(
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .field_x        (in_ch.field_x),
    .field_y        (in_ch.field_y),
    .field_z        (in_ch.field_z),
    .prev_field_x   (in_ch.prev_field_x),
    .prev_field_y   (in_ch.prev_field_y),
    .prev_field_z   (in_ch.prev_field_z),
    .field_norm     (in_ch.field_norm),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .coil_current_x (out_ch.coil_current_x),
    .coil_current_y (out_ch.coil_current_y),
    .coil_current_z (out_ch.coil_current_z),
    .saturated      (out_ch.saturated)
  );

  // The block goes busy right after it takes a sample.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input still ready after a sample was taken");

  // A new result is only loaded while a sample is being worked on.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared without a sample in progress");

  // The saturation flag implies at least one axis sits at a rail.
  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.saturated) |->
      (out_ch.coil_current_x == 8'sd127 || out_ch.coil_current_x == -8'sd128 ||
       out_ch.coil_current_y == 8'sd127 || out_ch.coil_current_y == -8'sd128 ||
       out_ch.coil_current_z == 8'sd127 || out_ch.coil_current_z == -8'sd128))
    else $error("saturation flag set with no axis at a rail");

endmodule
